>>> design/taim_pkg.sv
package taim_pkg;

  localparam logic [15:0] NONE_PENDING = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_SET_ENTRY  = 2'd0,
    MODE_POST       = 2'd1,
    MODE_START_PASS = 2'd2,
    MODE_ACK        = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

>>> design/tx_ack_masked_id_matcher.sv
// Transmit acknowledge matcher over a table of handles.
// Input beats arrive on start/in_*: an item is taken when start is high and busy is low.
// in_mode selects set_entry, post, start_pass or ack. set_entry, post and start_pass
// never raise busy. An ack opens a scan of the current window, one table entry per
// cycle through a single masked compare unit fed by the table memories; the scan
// holds busy high while it runs. The window length is at most NUM_ENTRIES. An ack
// after the pass is done, or on an empty window, does not raise busy.
// Each confirmation is one out_valid beat on out_*, in ascending entry order; out_last
// marks the final beat of an ack. The receiver cannot stall: every beat stands for
// exactly one cycle. The first beat appears in the cycle after the second match is
// compared, and the final beat appears in the same cycle that busy falls.
// cfg_we/cfg_wdata write entries_in_use, used at the next start_pass.
// Reset (rst_n low, synchronous) marks every entry as not pending, closes the pass,
// and sets entries_in_use to 16. Expected ids and masks hold no value until written.
module tx_ack_masked_id_matcher
  import taim_pkg::*;
#(
  parameter int NUM_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_expected_id,
  input  logic [31:0] in_id_mask,
  input  logic [15:0] in_message_id,
  input  logic [31:0] in_ack_word,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        out_valid,
  output logic [15:0] out_confirmed_message,
  output logic [3:0]  out_confirmed_entry,
  output logic        out_last
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  logic [31:0] exp_mem  [NUM_ENTRIES];
  logic [31:0] mask_mem [NUM_ENTRIES];
  logic [15:0] pend_mem [NUM_ENTRIES];
  logic [31:0] exp_q;
  logic [31:0] mask_q;
  logic [15:0] pend_q;

  state_t           state_r, state_nxt;
  logic [4:0]       cfg_entries_r;
  logic [NUM_ENTRIES-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0] win_lo_r, win_lo_nxt;
  logic [CNT_W-1:0] win_hi_r, win_hi_nxt;
  logic             win_done_r, win_done_nxt;
  logic [31:0]      ack_r;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             left_r, left_nxt;
  logic [IDX_W-1:0] left_lo_r, left_lo_nxt;
  logic [IDX_W-1:0] left_hi_r, left_hi_nxt;
  logic             hold_vld_r, hold_vld_nxt;
  logic [15:0]      hold_msg_r, hold_msg_nxt;
  logic [IDX_W-1:0] hold_idx_r, hold_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_msg_r, out_msg_nxt;
  logic [3:0]       out_entry_r, out_entry_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  logic             idx_ok;
  logic [IDX_W-1:0] wr_idx;
  logic             tbl_we;
  logic             pend_we;
  logic             rd_en;
  logic [CNT_W-1:0] pass_hi;
  logic [15:0]      cmp_pend;
  logic             is_pend;
  logic             hit;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;
  assign idx_ok = ({3'b000, in_entry_index} < 7'(NUM_ENTRIES));
  assign wr_idx = IDX_W'(in_entry_index);
  assign tbl_we  = accept && (mode_t'(in_mode) == MODE_SET_ENTRY) && idx_ok;
  assign pend_we = accept && (mode_t'(in_mode) == MODE_POST) && idx_ok;
  assign rd_en   = (state_r == ST_SCAN) && (rd_idx_r < win_hi_r);
  assign pass_hi = ({2'b00, cfg_entries_r} > 7'(NUM_ENTRIES)) ?
                   CNT_W'(NUM_ENTRIES) : CNT_W'(cfg_entries_r);

  assign cmp_pend = vld_r[cmp_idx_r] ? pend_q : NONE_PENDING;
  assign is_pend  = (cmp_pend != NONE_PENDING);
  assign hit      = ((ack_r & mask_q) == exp_q);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      exp_mem[wr_idx]  <= in_expected_id;
      mask_mem[wr_idx] <= in_id_mask;
    end
    if (pend_we) begin
      pend_mem[wr_idx] <= in_message_id;
    end
    if (rd_en) begin
      exp_q  <= exp_mem[rd_idx_r[IDX_W-1:0]];
      mask_q <= mask_mem[rd_idx_r[IDX_W-1:0]];
      pend_q <= pend_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    vld_nxt       = vld_r;
    win_lo_nxt    = win_lo_r;
    win_hi_nxt    = win_hi_r;
    win_done_nxt  = win_done_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    left_nxt      = left_r;
    left_lo_nxt   = left_lo_r;
    left_hi_nxt   = left_hi_r;
    hold_vld_nxt  = hold_vld_r;
    hold_msg_nxt  = hold_msg_r;
    hold_idx_nxt  = hold_idx_r;
    out_valid_nxt = 1'b0;
    out_msg_nxt   = out_msg_r;
    out_entry_nxt = out_entry_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_t'(in_mode))
            MODE_SET_ENTRY: begin
              if (idx_ok) begin
                vld_nxt[wr_idx] = 1'b0;
              end
            end
            MODE_POST: begin
              if (idx_ok) begin
                vld_nxt[wr_idx] = 1'b1;
              end
            end
            MODE_START_PASS: begin
              win_lo_nxt   = '0;
              win_hi_nxt   = pass_hi;
              win_done_nxt = 1'b0;
            end
            MODE_ACK: begin
              if (!win_done_r) begin
                if (win_lo_r < win_hi_r) begin
                  state_nxt    = ST_SCAN;
                  rd_idx_nxt   = win_lo_r;
                  left_nxt     = 1'b0;
                  hold_vld_nxt = 1'b0;
                end else begin
                  win_done_nxt = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (is_pend) begin
            if (hit) begin
              // A match is held back one beat so that the final one can carry last.
              vld_nxt[cmp_idx_r] = 1'b0;
              if (hold_vld_r) begin
                out_valid_nxt = 1'b1;
                out_msg_nxt   = hold_msg_r;
                out_entry_nxt = 4'(hold_idx_r);
                out_last_nxt  = 1'b0;
              end
              hold_vld_nxt = 1'b1;
              hold_msg_nxt = cmp_pend;
              hold_idx_nxt = cmp_idx_r;
            end else begin
              if (!left_r) begin
                left_lo_nxt = cmp_idx_r;
              end
              left_hi_nxt = cmp_idx_r;
              left_nxt    = 1'b1;
            end
          end
        end else if (!rd_en) begin
          state_nxt = ST_IDLE;
          if (hold_vld_r) begin
            out_valid_nxt = 1'b1;
            out_msg_nxt   = hold_msg_r;
            out_entry_nxt = 4'(hold_idx_r);
            out_last_nxt  = 1'b1;
          end
          if (left_r) begin
            win_lo_nxt = CNT_W'(left_lo_r);
            win_hi_nxt = CNT_W'(left_hi_r) + 1'b1;
          end else begin
            win_done_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cfg_entries_r <= 5'd16;
      vld_r         <= '0;
      win_lo_r      <= '0;
      win_hi_r      <= '0;
      win_done_r    <= 1'b1;
      cmp_vld_r     <= 1'b0;
      hold_vld_r    <= 1'b0;
      left_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_we) begin
        cfg_entries_r <= cfg_wdata;
      end
      vld_r       <= vld_nxt;
      win_lo_r    <= win_lo_nxt;
      win_hi_r    <= win_hi_nxt;
      win_done_r  <= win_done_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hold_vld_r  <= hold_vld_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ack_r <= in_ack_word;
    end
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    left_lo_r   <= left_lo_nxt;
    left_hi_r   <= left_hi_nxt;
    hold_msg_r  <= hold_msg_nxt;
    hold_idx_r  <= hold_idx_nxt;
    out_msg_r   <= out_msg_nxt;
    out_entry_r <= out_entry_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_confirmed_message = out_msg_r;
  assign out_confirmed_entry   = out_entry_r;
  assign out_last              = out_last_r;

endmodule

>>> bench/tx_ack_confirm_checker.sv
`timescale 1ns / 1ps

module tx_ack_confirm_checker
  import taim_pkg::*;
#(
  parameter int NUM_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_expected_id,
  input  logic [31:0] in_id_mask,
  input  logic [15:0] in_message_id,
  input  logic [31:0] in_ack_word,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        out_valid,
  input  logic [15:0] out_confirmed_message,
  input  logic [3:0]  out_confirmed_entry,
  input  logic        out_last,
  input  logic        drain_check,
  output int          fail_count,
  output int          confirms_waiting,
  output int          confirms_seen,
  output int          beats_taken
);

  typedef struct packed {
    logic [15:0] message;
    logic [3:0]  entry;
    logic        last;
  } confirm_t;

  confirm_t    confirms_due[$];
  logic [31:0] tab_expected [NUM_ENTRIES];
  logic [31:0] tab_mask [NUM_ENTRIES];
  logic [15:0] tab_pending [NUM_ENTRIES];
  logic [4:0]  entries_in_use;
  logic [4:0]  win_low;
  logic [4:0]  win_high;
  logic        win_done;
  bit          drained;

  task automatic predict_confirms(input mode_t mode, input logic [3:0] idx,
                                  input logic [31:0] exp_id, input logic [31:0] mask,
                                  input logic [15:0] msg, input logic [31:0] ack);
    confirm_t   found [NUM_ENTRIES];
    int         n;
    int         scan_end;
    logic [4:0] lo;
    logic [4:0] hi;
    bit         any_left;
    n = 0;
    lo = '0;
    hi = '0;
    any_left = 1'b0;
    case (mode)
      MODE_SET_ENTRY: begin
        if (int'(idx) < NUM_ENTRIES) begin
          tab_expected[idx] = exp_id;
          tab_mask[idx] = mask;
          tab_pending[idx] = NONE_PENDING;
        end
      end
      MODE_POST: begin
        if (int'(idx) < NUM_ENTRIES) tab_pending[idx] = msg;
      end
      MODE_START_PASS: begin
        win_low = '0;
        win_high = (entries_in_use > NUM_ENTRIES) ? 5'(NUM_ENTRIES) : entries_in_use;
        win_done = 1'b0;
      end
      MODE_ACK: begin
        if (!win_done) begin
          scan_end = (win_high > NUM_ENTRIES) ? NUM_ENTRIES : int'(win_high);
          for (int i = int'(win_low); i < scan_end; i++) begin
            if (tab_pending[i] != NONE_PENDING) begin
              if ((ack & tab_mask[i]) == tab_expected[i]) begin
                found[n] = '{message: tab_pending[i], entry: 4'(i), last: 1'b0};
                tab_pending[i] = NONE_PENDING;
                n++;
              end else begin
                if (!any_left) lo = 5'(i);
                hi = 5'(i);
                any_left = 1'b1;
              end
            end
          end
          if (n > 0) found[n - 1].last = 1'b1;
          for (int k = 0; k < n; k++) confirms_due.push_back(found[k]);
          if (any_left) begin
            win_low = lo;
            win_high = hi + 5'd1;
          end else begin
            win_done = 1'b1;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    confirm_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) tab_pending[i] = NONE_PENDING;
      entries_in_use = 5'd16;
      win_low = '0;
      win_high = '0;
      win_done = 1'b1;
      confirms_due.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        confirms_seen++;
        if (confirms_due.size() == 0) begin
          $error("Result beat with no confirmation expected: entry %0d, message %h",
                 out_confirmed_entry, out_confirmed_message);
          fail_count++;
        end else begin
          want = confirms_due.pop_front();
          if (out_confirmed_message !== want.message) begin
            $error("confirmed_message: expected %h, got %h",
                   want.message, out_confirmed_message);
            fail_count++;
          end
          if (out_confirmed_entry !== want.entry) begin
            $error("confirmed_entry: expected %0d, got %0d", want.entry, out_confirmed_entry);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        beats_taken++;
        predict_confirms(mode_t'(in_mode), in_entry_index, in_expected_id, in_id_mask,
                         in_message_id, in_ack_word);
      end
      if (cfg_we === 1'b1) entries_in_use = cfg_wdata;
      if (drain_check && !drained) begin
        drained = 1'b1;
        if (confirms_due.size() != 0) begin
          $error("%0d confirmations never arrived", confirms_due.size());
          fail_count += confirms_due.size();
        end
      end
    end
    confirms_waiting = confirms_due.size();
  end

endmodule

>>> bench/tx_ack_masked_id_matcher_test.sv
`timescale 1ns / 1ps

module tx_ack_masked_id_matcher_test
  import taim_pkg::*;
();

  localparam int NUM_ENTRIES = 16;
  localparam int SETTLE_CYCLES = NUM_ENTRIES + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 24;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [3:0]  in_entry_index;
  logic [31:0] in_expected_id;
  logic [31:0] in_id_mask;
  logic [15:0] in_message_id;
  logic [31:0] in_ack_word;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        out_valid;
  logic [15:0] out_confirmed_message;
  logic [3:0]  out_confirmed_entry;
  logic        out_last;
  logic        drain_check;
  int          fail_count;
  int          confirms_waiting;
  int          confirms_seen;
  int          beats_taken;

  logic [31:0] shadow_expected [NUM_ENTRIES];
  logic [31:0] shadow_mask [NUM_ENTRIES];
  bit          written [NUM_ENTRIES];
  int          idle_pct;
  int          items_sent;
  int          settings_run;
  int          cycles;

  tx_ack_masked_id_matcher #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_mode               (in_mode),
    .in_entry_index        (in_entry_index),
    .in_expected_id        (in_expected_id),
    .in_id_mask            (in_id_mask),
    .in_message_id         (in_message_id),
    .in_ack_word           (in_ack_word),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_confirmed_message (out_confirmed_message),
    .out_confirmed_entry   (out_confirmed_entry),
    .out_last              (out_last)
  );

  tx_ack_confirm_checker #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_mode               (in_mode),
    .in_entry_index        (in_entry_index),
    .in_expected_id        (in_expected_id),
    .in_id_mask            (in_id_mask),
    .in_message_id         (in_message_id),
    .in_ack_word           (in_ack_word),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_confirmed_message (out_confirmed_message),
    .out_confirmed_entry   (out_confirmed_entry),
    .out_last              (out_last),
    .drain_check           (drain_check),
    .fail_count            (fail_count),
    .confirms_waiting      (confirms_waiting),
    .confirms_seen         (confirms_seen),
    .beats_taken           (beats_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles without finishing.", cycles);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic issue(input mode_t mode, input logic [3:0] idx, input logic [31:0] exp_id,
                       input logic [31:0] mask, input logic [15:0] msg,
                       input logic [31:0] ack, input bit counted);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_mode <= mode;
    in_entry_index <= idx;
    in_expected_id <= exp_id;
    in_id_mask <= mask;
    in_message_id <= msg;
    in_ack_word <= ack;
    if (mode == MODE_SET_ENTRY) begin
      shadow_expected[idx] = exp_id;
      shadow_mask[idx] = mask;
      written[idx] = 1'b1;
    end
    do @(posedge clk); while (busy !== 1'b0);
    if (counted) items_sent++;
  endtask

  task automatic set_entry(input logic [3:0] idx, input logic [31:0] exp_id,
                           input logic [31:0] mask);
    issue(MODE_SET_ENTRY, idx, exp_id, mask, 16'($urandom), $urandom, 1'b1);
  endtask

  task automatic post(input logic [3:0] idx, input logic [15:0] msg);
    issue(MODE_POST, idx, $urandom, $urandom, msg, $urandom, 1'b1);
  endtask

  task automatic open_pass();
    issue(MODE_START_PASS, 4'($urandom), $urandom, $urandom, 16'($urandom), $urandom, 1'b1);
  endtask

  task automatic send_ack(input logic [31:0] word, input bit counted);
    issue(MODE_ACK, 4'($urandom), $urandom, $urandom, 16'($urandom), word, counted);
  endtask

  function automatic logic [3:0] any_written();
    int j;
    j = $urandom_range(NUM_ENTRIES - 1);
    while (!written[j]) j = (j + 1) % NUM_ENTRIES;
    return 4'(j);
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(4))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_FFFF;
      2: return 32'h0;
      3: return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_message();
    if ($urandom_range(19) == 0) return NONE_PENDING;
    return 16'($urandom_range(65534));
  endfunction

  task automatic quiesce();
    @(negedge clk);
    start <= 1'b0;
    while (confirms_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_entries_in_use(input logic [4:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Mostly well-formed rounds: load, post, open a pass, then acks aimed at loaded entries.
  task automatic run_round();
    int          j;
    logic [31:0] m;
    repeat ($urandom_range(0, 2)) begin
      j = $urandom_range(NUM_ENTRIES - 1);
      m = pick_mask();
      set_entry(4'(j), ($urandom_range(99) < 85) ? ($urandom & m) : $urandom, m);
    end
    repeat ($urandom_range(1, 6)) post(any_written(), pick_message());
    if ($urandom_range(99) < 90) open_pass();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(99) < 20) post(any_written(), pick_message());
      if ($urandom_range(99) < 75) begin
        j = any_written();
        send_ack((shadow_expected[j] & shadow_mask[j]) | ($urandom & ~shadow_mask[j]), 1'b1);
      end else begin
        send_ack($urandom, 1'b0);
      end
    end
  endtask

  initial begin
    int cfg_plan [6];
    int idle_plan [6];
    cfg_plan = '{31, 0, 5, 16, 1, 16};
    idle_plan = '{15, 15, 81, 81, 0, 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_SET_ENTRY;
    in_entry_index = '0;
    in_expected_id = '0;
    in_id_mask = '0;
    in_message_id = '0;
    in_ack_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    drain_check = 1'b0;
    idle_pct = 0;
    items_sent = 0;
    settings_run = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_entry(4'd0, 32'h0, 32'h0);
    set_entry(4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_entry(4'd15, 32'h0000_1234, 32'h0000_FFFF);
    set_entry(4'd7, 32'hA500_0000, 32'hFF00_0000);
    send_ack(32'hFFFF_FFFF, 1'b0);
    post(4'd0, 16'h0000);
    post(4'd1, 16'hFFFE);
    post(4'd15, 16'h1234);
    post(4'd7, 16'h0007);
    open_pass();
    send_ack(32'hFFFF_FFFF, 1'b1);
    post(4'd0, 16'h0005);
    send_ack(32'hA500_1234, 1'b1);
    send_ack(32'h0, 1'b0);
    open_pass();
    send_ack(32'h0, 1'b1);
    post(4'd1, NONE_PENDING);
    open_pass();
    send_ack($urandom, 1'b0);
    send_ack($urandom, 1'b0);
    post(4'd1, 16'h0001);
    open_pass();
    send_ack(32'h0, 1'b1);
    send_ack(32'hFFFF_FFFF, 1'b1);

    for (int p = 0; p < 6; p++) begin
      quiesce();
      write_entries_in_use((p == 4) ? 5'($urandom_range(31)) : 5'(cfg_plan[p]));
      idle_pct = idle_plan[p];
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) run_round();
    end
    quiesce();
    @(negedge clk);
    drain_check <= 1'b1;
    @(negedge clk);

    $display("Applied %0d input beats across %0d settings of entries_in_use.",
             beats_taken, settings_run + 1);
    $display("Compared %0d confirmation beats with the sender idle at 15, 81 and 0 percent.",
             confirms_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/taim_pkg.sv
design/tx_ack_masked_id_matcher.sv
bench/tx_ack_confirm_checker.sv
bench/tx_ack_masked_id_matcher_test.sv
